/* design/msgdq_pkg.sv */
// Package for the message deque: field widths, operation and status codes,
// controller states and the controller/datapath command structs.
// No dependencies; every other design file refers to it by scoped names.
package msgdq_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int FUNC_W = 3;
  localparam int FWD_W  = 8;
  localparam int VAL_W  = 32;
  localparam int LEN_W  = 16;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH     = 3'd0,
    FUNC_PRI_PUSH = 3'd1,
    FUNC_REPEAT   = 3'd2,
    FUNC_POP      = 3'd3,
    FUNC_UNPOP    = 3'd4
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_DROPPED = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_EVICTED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [FWD_W-1:0] fwd;
    logic [VAL_W-1:0] val;
    logic [LEN_W-1:0] len;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_en;  // write zero at the clear address, advance it
    logic accept;    // capture the incoming request
    logic exec;      // run the operation, read the head slot
    logic load;      // move the staged result into the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
  } dp_status_t;

endpackage

/* design/msgdq_if.sv */
// Request and response channel interfaces of the message deque.
// Depends on msgdq_pkg for field widths.
interface msgdq_in_if;
  logic                            valid;
  logic                            ready;
  logic [msgdq_pkg::FUNC_W-1:0]    func;
  logic [msgdq_pkg::FWD_W-1:0]     forward_id;
  logic [msgdq_pkg::VAL_W-1:0]     value;
  logic [msgdq_pkg::LEN_W-1:0]     payload_length;

  modport source (output valid, func, forward_id, value, payload_length, input ready);
  modport sink   (input valid, func, forward_id, value, payload_length, output ready);
endinterface

interface msgdq_out_if;
  logic                            valid;
  logic                            ready;
  logic [msgdq_pkg::STAT_W-1:0]    status;
  logic                            out_valid;
  logic [msgdq_pkg::FWD_W-1:0]     out_forward_id;
  logic [msgdq_pkg::VAL_W-1:0]     out_value;
  logic [msgdq_pkg::LEN_W-1:0]     out_length;
  logic [msgdq_pkg::SLOT_W-1:0]    slot_index;
  logic                            now_empty;
  logic                            now_full;
  logic [msgdq_pkg::SLOT_W-1:0]    occupancy;

  modport source (output valid, status, out_valid, out_forward_id, out_value, out_length,
                  slot_index, now_empty, now_full, occupancy, input ready);
  modport sink   (input valid, status, out_valid, out_forward_id, out_value, out_length,
                  slot_index, now_empty, now_full, occupancy, output ready);
endinterface

/* design/msgdq_ctrl.sv */
// Controller of the message deque: clear sweep, request sequencing and
// the response register's occupancy flag. Depends on msgdq_pkg.
module msgdq_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output msgdq_pkg::ctrl_cmd_t   cmd,
  input  msgdq_pkg::dp_status_t  stat
);

  msgdq_pkg::state_t state, state_next;
  logic              out_full;
  logic              load_ok;

  // output register can take a new result when empty or being drained
  assign load_ok = !out_full || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= msgdq_pkg::ST_CLEAR;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_full <= 1'b1;
      end else if (rsp_ready) begin
        out_full <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      msgdq_pkg::ST_CLEAR: begin
        if (stat.clear_done) state_next = msgdq_pkg::ST_IDLE;
      end
      msgdq_pkg::ST_IDLE: begin
        if (req_valid) state_next = msgdq_pkg::ST_EXEC;
      end
      msgdq_pkg::ST_EXEC: begin
        state_next = msgdq_pkg::ST_DONE;
      end
      msgdq_pkg::ST_DONE: begin
        if (load_ok) state_next = msgdq_pkg::ST_IDLE;
      end
      default: state_next = msgdq_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      msgdq_pkg::ST_CLEAR: cmd.clear_en = 1'b1;
      msgdq_pkg::ST_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
      end
      msgdq_pkg::ST_EXEC: cmd.exec = 1'b1;
      msgdq_pkg::ST_DONE: cmd.load = load_ok;
      default: cmd = '0;
    endcase
  end

  assign rsp_valid = out_full;

endmodule

/* design/msgdq_dp.sv */
// Datapath of the message deque: pointers, descriptor memory, request,
// staged result and output registers. Depends on msgdq_pkg.
module msgdq_dp #(
  parameter int DEPTH = msgdq_pkg::DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  msgdq_pkg::ctrl_cmd_t            cmd,
  output msgdq_pkg::dp_status_t           stat,
  input  logic [msgdq_pkg::FUNC_W-1:0]    func,
  input  logic [msgdq_pkg::FWD_W-1:0]     forward_id,
  input  logic [msgdq_pkg::VAL_W-1:0]     value,
  input  logic [msgdq_pkg::LEN_W-1:0]     payload_length,
  output logic [msgdq_pkg::STAT_W-1:0]    status,
  output logic                            out_valid,
  output logic [msgdq_pkg::FWD_W-1:0]     out_forward_id,
  output logic [msgdq_pkg::VAL_W-1:0]     out_value,
  output logic [msgdq_pkg::LEN_W-1:0]     out_length,
  output logic [msgdq_pkg::SLOT_W-1:0]    slot_index,
  output logic                            now_empty,
  output logic                            now_full,
  output logic [msgdq_pkg::SLOT_W-1:0]    occupancy
);

  localparam int PW = $clog2(DEPTH);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [PW:0]   DEPTH_X = (PW + 1)'(DEPTH);

  // pointers and clear sweep
  logic [PW-1:0] wp, rp, clr_addr;
  logic [PW-1:0] wp_next, rp_next;

  // captured request
  msgdq_pkg::func_t req_func;
  msgdq_pkg::entry_t req_entry;

  // descriptor memory
  msgdq_pkg::entry_t mem [DEPTH];
  msgdq_pkg::entry_t rd_data;
  logic              mem_we;
  logic [PW-1:0]     mem_waddr;
  msgdq_pkg::entry_t mem_wdata;

  // staged result
  msgdq_pkg::status_t st_status, st_status_next;
  logic               st_pop, st_pop_next;
  logic [PW-1:0]      st_slot, st_slot_next;
  logic               st_empty, st_full;
  logic [PW-1:0]      st_occ;

  logic           exec_we;
  logic [PW-1:0]  exec_waddr;
  logic           cur_empty, cur_full;
  logic [PW:0]    occ_diff;
  logic [PW+3:0]  slot_ext, occ_ext;

  function automatic logic [PW-1:0] step_fwd(input logic [PW-1:0] p);
    step_fwd = (p == LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] step_back(input logic [PW-1:0] p);
    step_back = (p == '0) ? LAST : p - 1'b1;
  endfunction

  assign stat.clear_done = (clr_addr == LAST);

  assign cur_empty = (wp == rp);
  assign cur_full  = (step_fwd(wp) == rp);

  always_comb begin
    wp_next        = wp;
    rp_next        = rp;
    st_status_next = msgdq_pkg::STAT_OK;
    st_pop_next    = 1'b0;
    st_slot_next   = rp;
    exec_we        = 1'b0;
    exec_waddr     = wp;
    case (req_func)
      msgdq_pkg::FUNC_PUSH: begin
        st_slot_next = wp;
        if (cur_full) begin
          st_status_next = msgdq_pkg::STAT_DROPPED;
        end else begin
          exec_we = 1'b1;
          wp_next = step_fwd(wp);
        end
      end
      msgdq_pkg::FUNC_PRI_PUSH, msgdq_pkg::FUNC_REPEAT: begin
        if (cur_full) begin
          wp_next        = step_back(wp);
          st_status_next = msgdq_pkg::STAT_EVICTED;
        end
        rp_next      = step_back(rp);
        st_slot_next = rp_next;
        exec_waddr   = rp_next;
        exec_we      = (req_func == msgdq_pkg::FUNC_PRI_PUSH);
      end
      msgdq_pkg::FUNC_POP: begin
        if (cur_empty) begin
          st_status_next = msgdq_pkg::STAT_EMPTY;
        end else begin
          st_pop_next = 1'b1;
          rp_next     = step_fwd(rp);
        end
      end
      msgdq_pkg::FUNC_UNPOP: begin
        if (!cur_empty) rp_next = step_back(rp);
        st_slot_next = rp_next;
      end
      default: st_slot_next = rp;
    endcase
  end

  // (wp - rp) mod DEPTH on the updated pointers
  always_comb begin
    if (wp_next >= rp_next) begin
      occ_diff = {1'b0, wp_next} - {1'b0, rp_next};
    end else begin
      occ_diff = {1'b0, wp_next} + DEPTH_X - {1'b0, rp_next};
    end
  end

  assign mem_we    = cmd.clear_en || (cmd.exec && exec_we);
  assign mem_waddr = cmd.clear_en ? clr_addr : exec_waddr;
  assign mem_wdata = cmd.clear_en ? '0 : req_entry;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.exec) rd_data <= mem[rp];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      rp       <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.clear_en) clr_addr <= step_fwd(clr_addr);
      if (cmd.exec) begin
        wp <= wp_next;
        rp <= rp_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_func  <= msgdq_pkg::func_t'(func);
      req_entry <= '{fwd: forward_id, val: value, len: payload_length};
    end
    if (cmd.exec) begin
      st_status <= st_status_next;
      st_pop    <= st_pop_next;
      st_slot   <= st_slot_next;
      st_empty  <= (wp_next == rp_next);
      st_full   <= (step_fwd(wp_next) == rp_next);
      st_occ    <= occ_diff[PW-1:0];
    end
  end

  assign slot_ext = {4'b0, st_slot};
  assign occ_ext  = {4'b0, st_occ};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status         <= st_status;
      out_valid      <= st_pop;
      out_forward_id <= st_pop ? rd_data.fwd : '0;
      out_value      <= st_pop ? rd_data.val : '0;
      out_length     <= st_pop ? rd_data.len : '0;
      slot_index     <= slot_ext[3:0];
      now_empty      <= st_empty;
      now_full       <= st_full;
      occupancy      <= occ_ext[3:0];
    end
  end

endmodule

/* design/message_deque_with_priority_insert.sv */
// Top level of the message deque with priority insert: joins controller
// and datapath to the request and response channels. Depends on msgdq_pkg,
// msgdq_in_if, msgdq_out_if, msgdq_ctrl and msgdq_dp.
//
//   channel  dir  handshake        payload
//   req      in   valid / ready    func, forward_id, value, payload_length
//   rsp      out  valid / ready    status, out_valid, out_forward_id, out_value,
//                                  out_length, slot_index, now_empty, now_full,
//                                  occupancy
//
// A response is valid once its request is accepted, executed (with the
// registered descriptor read) and then loaded into the output register. A new
// request is accepted only after the previous one is loaded. The single memory
// read port sets the middle step.
// After rst the descriptor memory is cleared one slot per cycle; req.ready is
// low until all are cleared. A stalled response holds; the next request is
// still accepted and waits in its load step until the output register is free.
module message_deque_with_priority_insert #(
  parameter int DEPTH = msgdq_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  msgdq_in_if.sink    req,
  msgdq_out_if.source rsp
);

  msgdq_pkg::ctrl_cmd_t  cmd;
  msgdq_pkg::dp_status_t stat;

  msgdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  msgdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .func           (req.func),
    .forward_id     (req.forward_id),
    .value          (req.value),
    .payload_length (req.payload_length),
    .status         (rsp.status),
    .out_valid      (rsp.out_valid),
    .out_forward_id (rsp.out_forward_id),
    .out_value      (rsp.out_value),
    .out_length     (rsp.out_length),
    .slot_index     (rsp.slot_index),
    .now_empty      (rsp.now_empty),
    .now_full       (rsp.now_full),
    .occupancy      (rsp.occupancy)
  );

endmodule
